// File: rtl/utf8_to_utf16_transcoder_defines.svh
// assertion macros for the utf8 to utf16 transcoder checker
// no dependencies; included by the checker file
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// clocked assertion, masked while reset is held
`define U8U16_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define U8U16_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: rtl/u8u16_pkg.sv
// shared types and constants of the utf8 to utf16 transcoder
// no dependencies
package u8u16_pkg;

    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 31;

    // top six bits of high and low surrogate units
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    localparam logic [ACC_W-1:0] BMP_MAX  = 31'h0000_ffff;
    localparam logic [ACC_W-1:0] SUPP_OFS = 31'h0001_0000;

    typedef struct packed {
        logic              string_end;
        logic              run_end;
        logic [UNIT_W-1:0] code_unit;
    } u8u16_result_t;

endpackage

// File: rtl/utf8_to_utf16_transcoder.sv
// utf8 to utf16 transcoder top level: decoder state plus a four-entry result buffer
// depends on u8u16_pkg
//
// Takes one UTF-8 byte per input transaction (s_tdata) and produces UTF-16 code
// units on the master side. ASCII passes through; lead bytes of 2 to 6 byte
// sequences start a sequence, continuation bytes shift in six bits each, and the
// last one emits one unit (value up to 0xffff) or a surrogate pair, high unit
// first. Stray continuation bytes, 0xfe and 0xff give nothing; a non-continuation
// byte in mid-sequence drops the sequence and is decoded as a fresh byte. A zero
// byte ends the string with a zero unit flagged on m_tuser. m_tlast marks the last
// unit caused by one input byte. The decoder takes one byte every cycle while
// s_tready is high: all the work sits in one pass of logic in front of the result
// buffer. The buffer holds four results and s_tready is high while it holds at
// most two, so the input side never waits on a combinational path from m_tready.
// Sustained rate is one byte per cycle as long as the sink takes one unit per
// cycle; a byte that yields a surrogate pair needs two output transfers. No
// overlong or surrogate range checks are made.
module utf8_to_utf16_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // utf16 unit stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // [0] string_end
);
    import u8u16_pkg::*;

    // decoder state
    logic [2:0]       pend_reg, pend_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    // result buffer
    u8u16_result_t    buf_mem [4];
    logic [1:0]       wp_reg, rp_reg;
    logic [2:0]       cnt_reg;

    logic             s_xfer, m_xfer;
    logic [1:0]       n_push;
    u8u16_result_t    res0, res1;
    logic [BYTE_W-1:0] b;
    logic             is_cont;
    logic [ACC_W-1:0] acc_shift, supp;
    logic [2:0]       pend_dec;
    logic [1:0]       wp1;

    assign b         = s_tdata;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid && m_tready;
    assign is_cont   = (b[7:6] == 2'b10);
    assign acc_shift = {acc_reg[ACC_W-7:0], b[5:0]};
    assign pend_dec  = pend_reg - 3'd1;
    assign supp      = acc_shift - SUPP_OFS;
    assign wp1       = wp_reg + 2'd1;

    // single pass decode of one byte against the current sequence state
    always_comb begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        n_push    = 2'd0;
        res0      = '0;
        res1      = '0;
        if (pend_reg != 3'd0 && is_cont) begin
            // continuation byte inside a sequence
            pend_next = pend_dec;
            acc_next  = acc_shift;
            if (pend_dec == 3'd0) begin
                acc_next = '0;
                if (acc_shift <= BMP_MAX) begin
                    n_push         = 2'd1;
                    res0.code_unit = acc_shift[UNIT_W-1:0];
                    res0.run_end   = 1'b1;
                end else begin
                    // bits above 19 of the offset value are dropped
                    n_push         = 2'd2;
                    res0.code_unit = {HI_SURR_TAG, supp[19:10]};
                    res1.code_unit = {LO_SURR_TAG, supp[9:0]};
                    res1.run_end   = 1'b1;
                end
            end
        end else begin
            // fresh byte, any broken sequence is dropped
            pend_next = 3'd0;
            acc_next  = '0;
            priority if (b == 8'h00) begin
                n_push          = 2'd1;
                res0.run_end    = 1'b1;
                res0.string_end = 1'b1;
            end else if (!b[7]) begin
                n_push         = 2'd1;
                res0.code_unit = {8'h00, b};
                res0.run_end   = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                pend_next = 3'd1;
                acc_next  = {26'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                pend_next = 3'd2;
                acc_next  = {27'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                pend_next = 3'd3;
                acc_next  = {28'd0, b[2:0]};
            end else if (b[7:2] == 6'b111110) begin
                pend_next = 3'd4;
                acc_next  = {29'd0, b[1:0]};
            end else if (b[7:1] == 7'b1111110) begin
                pend_next = 3'd5;
                acc_next  = {30'd0, b[0]};
            end else begin
                // stray continuation, 0xfe or 0xff: nothing
                pend_next = 3'd0;
            end
        end
    end

    // decoder state and buffer pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
            acc_reg  <= '0;
            wp_reg   <= 2'd0;
            rp_reg   <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            if (s_xfer) begin
                pend_reg <= pend_next;
                acc_reg  <= acc_next;
                wp_reg   <= wp_reg + (s_xfer ? n_push : 2'd0);
            end
            if (m_xfer) begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {1'b0, (s_xfer ? n_push : 2'd0)} - {2'b00, m_xfer};
        end
    end

    // buffer storage, payload only
    always_ff @(posedge aclk) begin
        if (s_xfer && n_push != 2'd0) begin
            buf_mem[wp_reg] <= res0;
        end
        if (s_xfer && n_push == 2'd2) begin
            buf_mem[wp1] <= res1;
        end
    end

    // room for a full pair regardless of the sink
    assign s_tready = (cnt_reg <= 3'd2);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = buf_mem[rp_reg].code_unit;
    assign m_tlast  = buf_mem[rp_reg].run_end;
    assign m_tuser  = buf_mem[rp_reg].string_end;

endmodule

// File: rtl/u8u16_checker.sv
// port-level checker for the utf8 to utf16 transcoder, bound to the top level
// depends on u8u16_pkg and utf8_to_utf16_transcoder_defines.svh
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    import u8u16_pkg::*;

    // a stalled result holds
    `U8U16_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    // terminator is a zero unit that closes its byte
    `U8U16_ASSERT(a_term, m_tvalid && m_tuser |-> m_tlast && (m_tdata == 16'h0000), "bad terminator")

    // a taken high surrogate is followed at once by its low surrogate
    `U8U16_ASSERT(a_pair, m_tvalid && m_tready && !m_tlast |-> (m_tdata[15:10] == HI_SURR_TAG) ##1 m_tvalid && m_tlast && (m_tdata[15:10] == LO_SURR_TAG), "broken surrogate pair")

    // nothing is offered right after reset
    `U8U16_ASSERT_NR(a_rst, !aresetn |=> !m_tvalid && s_tready, "output not empty after reset")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: sim/u8u16_checker.sv
`timescale 1ns / 1ps
// checker for the utf8 to utf16 transcoder: predicts the units each accepted byte
// should cause, then compares every output transaction against the oldest prediction
// depends on u8u16_pkg
module u8u16_tb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          fail_count,
    output int          exp_count,
    output int          unit_count,
    output int          pair_count,
    output int          term_count
);
    import u8u16_pkg::*;

    localparam int MAX_PRINTS = 40;

    // decoder state as the block should hold it
    logic [2:0]       seq_left;
    logic [ACC_W-1:0] seq_acc;

    u8u16_result_t units_due[$];

    initial begin
        fail_count = 0;
        exp_count  = 0;
        unit_count = 0;
        pair_count = 0;
        term_count = 0;
        seq_left   = '0;
        seq_acc    = '0;
    end

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic push_unit(input logic [15:0] cu, input logic last, input logic term);
        u8u16_result_t r;
        r.code_unit  = cu;
        r.run_end    = last;
        r.string_end = term;
        units_due.push_back(r);
    endtask

    // emit the finished code point: one unit in the bmp, else a surrogate pair
    task automatic emit_point(input logic [ACC_W-1:0] cp);
        logic [ACC_W-1:0] ofs;
        if (cp <= BMP_MAX) begin
            push_unit(cp[15:0], 1'b1, 1'b0);
        end else begin
            ofs = cp - SUPP_OFS;
            push_unit({HI_SURR_TAG, ofs[19:10]}, 1'b0, 1'b0);
            push_unit({LO_SURR_TAG, ofs[9:0]}, 1'b1, 1'b0);
            pair_count++;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic fresh;
        fresh = 1'b1;
        if (seq_left != 0) begin
            if (b[7:6] == 2'b10) begin
                fresh    = 1'b0;
                seq_acc  = {seq_acc[ACC_W-7:0], b[5:0]};
                seq_left = seq_left - 3'd1;
                if (seq_left == 0) begin
                    emit_point(seq_acc);
                    seq_acc = '0;
                end
            end else begin
                // broken sequence, byte gets decoded from scratch
                seq_left = '0;
                seq_acc  = '0;
            end
        end
        if (fresh) begin
            if (b == 8'h00) begin
                push_unit(16'h0000, 1'b1, 1'b1);
                term_count++;
            end else if (!b[7]) begin
                push_unit({8'h00, b}, 1'b1, 1'b0);
            end else begin
                casez (b)
                    8'b110?_????: begin seq_left = 3'd1; seq_acc = ACC_W'(b[4:0]); end
                    8'b1110_????: begin seq_left = 3'd2; seq_acc = ACC_W'(b[3:0]); end
                    8'b1111_0???: begin seq_left = 3'd3; seq_acc = ACC_W'(b[2:0]); end
                    8'b1111_10??: begin seq_left = 3'd4; seq_acc = ACC_W'(b[1:0]); end
                    8'b1111_110?: begin seq_left = 3'd5; seq_acc = ACC_W'(b[0]);   end
                    default: ; // stray continuation, 0xfe, 0xff
                endcase
            end
        end
    endtask

    always @(posedge aclk) begin
        u8u16_result_t want;
        if (!aresetn) begin
            units_due.delete();
            seq_left = '0;
            seq_acc  = '0;
        end else begin
            // output first: a unit leaving now belongs to an earlier byte
            if (m_tvalid && m_tready) begin
                unit_count++;
                if (units_due.size() == 0) begin
                    report($sformatf("unit 0x%04h arrived with nothing expected", m_tdata));
                end else begin
                    want = units_due.pop_front();
                    if (m_tdata !== want.code_unit)
                        report($sformatf("code_unit got 0x%04h want 0x%04h",
                                         m_tdata, want.code_unit));
                    if (m_tlast !== want.run_end)
                        report($sformatf("run_end got %b want %b on unit 0x%04h",
                                         m_tlast, want.run_end, want.code_unit));
                    if (m_tuser !== want.string_end)
                        report($sformatf("string_end got %b want %b on unit 0x%04h",
                                         m_tuser, want.string_end, want.code_unit));
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
        end
        exp_count = units_due.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// top of the utf8 to utf16 transcoder testbench: clock, reset, byte stimulus, sink stalls
// depends on u8u16_pkg, u8u16_tb_checker and the utf8_to_utf16_transcoder rtl
module tb_top;

    localparam int RAND_ITEMS   = 1950;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 16;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int fail_count, exp_count, unit_count, pair_count, term_count;
    int bytes_sent = 0;
    int cycles     = 0;
    // no idling on either side while this is set
    logic calm = 1'b0;

    utf8_to_utf16_transcoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] code_unit
        .m_tlast  (m_tlast),   // run_end
        .m_tuser  (m_tuser)    // [0] string_end
    );

    u8u16_tb_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .exp_count  (exp_count),
        .unit_count (unit_count),
        .pair_count (pair_count),
        .term_count (term_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d units still expected", cycles, exp_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // sink side: stalls about one cycle in ten unless calm
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // one input transaction; called and returning at a rising edge.
    // s_tready is sampled at the falling edge, where both sides are settled
    task automatic send_byte(input logic [7:0] b);
        logic ok;
        if (!calm) begin
            while ($urandom_range(0, 99) < 10) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        bytes_sent++;
    endtask

    // hold the sender off until every predicted unit has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (exp_count != 0);
        @(posedge aclk);
    endtask

    // lead byte of an n byte sequence with random payload bits
    function automatic logic [7:0] lead_byte(input int n);
        logic [7:0] pre;
        pre = 8'hff << (8 - n);
        return pre | (8'($urandom) & ((8'd1 << (7 - n)) - 8'd1));
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // well formed character of n bytes, payload random
    task automatic send_char(input int n);
        int i;
        if (n == 1) begin
            send_byte(8'($urandom_range(1, 127)));
        end else begin
            send_byte(lead_byte(n));
            for (i = 1; i < n; i++)
                send_byte(cont_byte());
        end
    endtask

    // fixed cases: ascii ends, sequence lengths 2, 3, 4 and 6, stray and invalid bytes,
    // broken sequences, terminator in mid-sequence, largest 6 byte value
    logic [7:0] directed_bytes[] = '{
        8'h41, 8'h7f,
        8'hc3, 8'ha9,                      // two byte
        8'he2, 8'h82, 8'hac,               // three byte
        8'hf0, 8'h9f, 8'h98, 8'h80,        // four byte, surrogate pair
        8'h80,                             // stray continuation
        8'hfe, 8'hff,                      // never valid
        8'he2, 8'h41,                      // broken by ascii
        8'hc3, 8'h00,                      // broken by terminator
        8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,   // above 0x10ffff, high bits dropped
        8'h00
    };

    initial begin
        int pick;
        int n;
        int k;
        int i;
        int useful;
        int next_drain;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain();

        useful     = 0;
        next_drain = 350;
        while (useful < RAND_ITEMS) begin
            // long stretch with no idling on either side
            calm <= (useful >= 700) && (useful < 1000);
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                n = $urandom_range(1, 6);
                send_char(n);
                useful += n;
            end else if (pick < 70) begin
                send_byte(8'h00);
                useful++;
            end else if (pick < 80) begin
                // sequence cut short by a byte that is not a continuation
                n = $urandom_range(2, 6);
                k = $urandom_range(0, n - 2);
                send_byte(lead_byte(n));
                for (i = 0; i < k; i++)
                    send_byte(cont_byte());
                case ($urandom_range(0, 2))
                    0: send_byte(8'($urandom_range(0, 127)));
                    1: send_byte(lead_byte($urandom_range(2, 6)));
                    default: send_byte(8'h00);
                endcase
                useful += k + 2;
            end else if (pick < 88) begin
                send_byte(cont_byte());
                useful++;
            end else if (pick < 92) begin
                send_byte($urandom_range(0, 1) ? 8'hfe : 8'hff);
                useful++;
            end else begin
                send_byte(8'($urandom));
                useful++;
            end
            if (useful >= next_drain) begin
                drain();
                next_drain += 350;
            end
        end

        calm <= 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d bytes (directed, well formed, broken, stray, invalid, terminators)",
                 bytes_sent);
        $display("checked %0d utf16 units: %0d surrogate pairs, %0d string terminators",
                 unit_count, pair_count, term_count);
        if (fail_count == 0 && exp_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d units never arrived", fail_count, exp_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: utf8_to_utf16_transcoder.f
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_transcoder.sv
rtl/u8u16_checker.sv
sim/u8u16_checker.sv
sim/tb_top.sv
